// File: hw/rtl/lsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lsc_pkg;

    localparam int MAX_BANK = 32;

    typedef enum logic [2:0] {
        CMD_TICK       = 3'd0,
        CMD_UNLOCK     = 3'd1,
        CMD_CHARGE_ON  = 3'd2,
        CMD_CHARGE_OFF = 3'd3,
        CMD_DOOR       = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_UPDATE    = 2'd0,
        KIND_FORWARD   = 2'd1,
        KIND_DOOR      = 2'd2,
        KIND_PULSE_END = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        LED_GREEN = 2'd0,
        LED_BLUE  = 2'd1,
        LED_AMBER = 2'd2
    } led_t;

    localparam logic REG_PULSE_TICKS    = 1'b0;
    localparam logic REG_HIGHEST_REMOTE = 1'b1;

    localparam logic [15:0] PULSE_TICKS_RESET    = 16'd200;
    localparam logic [5:0]  HIGHEST_REMOTE_RESET = 6'd38;

    // External ids of the local slots, by position.
    localparam logic [5:0] ID_TABLE [MAX_BANK] = '{
        6'd1,  6'd2,  6'd3,  6'd4,  6'd9,  6'd10, 6'd11, 6'd12,
        6'd13, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd29, 6'd30,
        6'd31, 6'd32, 6'd33, 6'd40, 6'd41, 6'd42, 6'd43, 6'd44,
        6'd45, 6'd46, 6'd47, 6'd48, 6'd49, 6'd50, 6'd51, 6'd52
    };

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch_in;
        logic ptr_hit;
        logic ptr_door;
        logic ptr_clear;
        logic ptr_inc;
        logic cmd_apply;
        logic build_slot;
        logic build_fwd;
        logic door_commit;
        logic tick_rd;
        logic tick_step;
        logic push_last;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        cmd_t cmd;
        logic hit;
        logic fwd_ok;
        logic door_ok;
        logic tick_stall;
        logic ptr_last;
        logic hold_valid;
        logic out_free;
    } dp_status_t;

    function automatic led_t led_of(input logic locked, input logic charging);
        led_t led;
        if (!locked) begin
            led = LED_GREEN;
        end else if (charging) begin
            led = LED_BLUE;
        end else begin
            led = LED_AMBER;
        end
        return led;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/locker_slot_controller.sv
`timescale 1ns / 1ps
`default_nettype none

// Locker slot controller.
// Requests arrive on the s_ channel (valid/ready) and carry a selector: tick,
// unlock, charge on, charge off or door sample. Results leave on the m_
// channel (valid/ready); m_last marks the final result of a request, and a
// request may give none. Configuration is written through cfg_we, cfg_index
// and cfg_wdata (index 0 pulse length in ticks, index 1 highest remote id);
// the user must write only while the block is idle; the block does not check.
// One request is handled at a time. A command for a local slot passes the
// decode, apply, build and finish states; a forward goes from decode to
// finish, and an ignored id or selector returns to idle from decode. A door
// sample with a change passes decode, door check and finish, and without one
// returns to idle after the door check. A tick walks the slots one by one,
// reading, then updating, each entry of the single-port elapsed-time memory.
// When the receiver stalls, one result waits in the output register and a
// second is held inside; the walk then pauses at the slot that produced a
// third until the output register frees up.
// Reset (aresetn, synchronous, active low) unlocks every slot, stops charging
// and all pulses, sets all door levels high and restores the default
// configuration; no clearing pass is needed.
module locker_slot_controller #(
    parameter int NUM_SLOTS = 19
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_we,
    input  wire         cfg_index,
    input  wire  [15:0] cfg_wdata,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [2:0]  s_cmd,
    input  wire  [5:0]  s_slot_id,
    input  wire  [4:0]  s_local_index,
    input  wire         s_door_first,
    input  wire         s_door_confirm,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [1:0]  m_kind,
    output logic [5:0]  m_out_slot_id,
    output logic        m_lock_drive,
    output logic        m_charge_drive,
    output logic [1:0]  m_led_color,
    output logic        m_door_level,
    output logic        m_last
);

    lsc_pkg::ctl_cmd_t   ctl;
    lsc_pkg::dp_status_t status;

    lsc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .ctl     (ctl)
    );

    lsc_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_cmd          (s_cmd),
        .s_slot_id      (s_slot_id),
        .s_local_index  (s_local_index),
        .s_door_first   (s_door_first),
        .s_door_confirm (s_door_confirm),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_out_slot_id  (m_out_slot_id),
        .m_lock_drive   (m_lock_drive),
        .m_charge_drive (m_charge_drive),
        .m_led_color    (m_led_color),
        .m_door_level   (m_door_level),
        .m_last         (m_last),
        .ctl            (ctl),
        .status         (status)
    );

endmodule

`default_nettype wire

// File: hw/rtl/lsc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module lsc_ctrl (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  lsc_pkg::dp_status_t status,
    output lsc_pkg::ctl_cmd_t   ctl
);

    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_DECODE    = 8'b0000_0010,
        ST_CMD_APPLY = 8'b0000_0100,
        ST_CMD_BUILD = 8'b0000_1000,
        ST_DOOR_CHK  = 8'b0001_0000,
        ST_TICK_RD   = 8'b0010_0000,
        ST_TICK_CHK  = 8'b0100_0000,
        ST_FINISH    = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    ctl.latch_in = 1'b1;
                    state_next   = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (status.cmd)
                    lsc_pkg::CMD_TICK: begin
                        ctl.ptr_clear = 1'b1;
                        state_next    = ST_TICK_RD;
                    end
                    lsc_pkg::CMD_UNLOCK, lsc_pkg::CMD_CHARGE_ON,
                    lsc_pkg::CMD_CHARGE_OFF: begin
                        if (status.hit) begin
                            ctl.ptr_hit = 1'b1;
                            state_next  = ST_CMD_APPLY;
                        end else if (status.fwd_ok) begin
                            ctl.build_fwd = 1'b1;
                            state_next    = ST_FINISH;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end
                    lsc_pkg::CMD_DOOR: begin
                        ctl.ptr_door = 1'b1;
                        state_next   = ST_DOOR_CHK;
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_CMD_APPLY: begin
                ctl.cmd_apply = 1'b1;
                state_next    = ST_CMD_BUILD;
            end
            ST_CMD_BUILD: begin
                ctl.build_slot = 1'b1;
                state_next     = ST_FINISH;
            end
            ST_DOOR_CHK: begin
                if (status.door_ok) begin
                    ctl.door_commit = 1'b1;
                    state_next      = ST_FINISH;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_TICK_RD: begin
                ctl.tick_rd = 1'b1;
                state_next  = ST_TICK_CHK;
            end
            ST_TICK_CHK: begin
                // A finished pulse cannot be taken while both the held result
                // and the output register are occupied; the slot is retried.
                if (!status.tick_stall) begin
                    ctl.tick_step = 1'b1;
                    if (status.ptr_last) begin
                        state_next = ST_FINISH;
                    end else begin
                        ctl.ptr_inc = 1'b1;
                        state_next  = ST_TICK_RD;
                    end
                end
            end
            ST_FINISH: begin
                if (!status.hold_valid) begin
                    state_next = ST_IDLE;
                end else if (status.out_free) begin
                    ctl.push_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_idle_no_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !status.hold_valid)
        else $error("held result left behind when returning to idle");

    a_finish_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && status.hold_valid && status.out_free)
            |=> state_reg == ST_IDLE)
        else $error("final result not released from finish state");

    a_stall_only_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TICK_CHK && status.tick_stall) |=> state_reg == ST_TICK_CHK)
        else $error("stalled slot check left before completing");

endmodule

`default_nettype wire

// File: hw/rtl/lsc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module lsc_datapath #(
    parameter int NUM_SLOTS = 19
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 cfg_we,
    input  wire                 cfg_index,
    input  wire  [15:0]         cfg_wdata,
    input  wire  [2:0]          s_cmd,
    input  wire  [5:0]          s_slot_id,
    input  wire  [4:0]          s_local_index,
    input  wire                 s_door_first,
    input  wire                 s_door_confirm,
    output logic                m_valid,
    input  wire                 m_ready,
    output logic [1:0]          m_kind,
    output logic [5:0]          m_out_slot_id,
    output logic                m_lock_drive,
    output logic                m_charge_drive,
    output logic [1:0]          m_led_color,
    output logic                m_door_level,
    output logic                m_last,
    input  lsc_pkg::ctl_cmd_t   ctl,
    output lsc_pkg::dp_status_t status
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);
    localparam logic [5:0] NUM_SLOTS_W6 = 6'(NUM_SLOTS);

    // Configuration.
    logic [15:0] pulse_ticks_reg;
    logic [5:0]  highest_remote_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_ticks_reg    <= lsc_pkg::PULSE_TICKS_RESET;
            highest_remote_reg <= lsc_pkg::HIGHEST_REMOTE_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                lsc_pkg::REG_PULSE_TICKS:    pulse_ticks_reg    <= cfg_wdata;
                lsc_pkg::REG_HIGHEST_REMOTE: highest_remote_reg <= cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    // Request capture.
    lsc_pkg::cmd_t cmd_reg;
    logic [5:0]    id_reg;
    logic [4:0]    local_index_reg;
    logic          first_reg;
    logic          confirm_reg;

    always_ff @(posedge aclk) begin
        if (ctl.latch_in) begin
            cmd_reg         <= lsc_pkg::cmd_t'(s_cmd);
            id_reg          <= s_slot_id;
            local_index_reg <= s_local_index;
            first_reg       <= s_door_first;
            confirm_reg     <= s_door_confirm;
        end
    end

    // Id lookup against the constant table; ids are distinct.
    logic             hit;
    logic [IDX_W-1:0] hit_idx;

    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (lsc_pkg::ID_TABLE[i] == id_reg) begin
                hit     = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end

    // Slot pointer: every per-slot read and write goes through it.
    logic [IDX_W-1:0] ptr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg <= '0;
        end else if (ctl.ptr_clear) begin
            ptr_reg <= '0;
        end else if (ctl.ptr_hit) begin
            ptr_reg <= hit_idx;
        end else if (ctl.ptr_door) begin
            ptr_reg <= local_index_reg[IDX_W-1:0];
        end else if (ctl.ptr_inc) begin
            ptr_reg <= ptr_reg + 1'b1;
        end
    end

    // Per-slot flags.
    logic [NUM_SLOTS-1:0] locked_reg;
    logic [NUM_SLOTS-1:0] charging_reg;
    logic [NUM_SLOTS-1:0] pulsing_reg;
    logic [NUM_SLOTS-1:0] door_reg;

    logic cur_locked;
    logic cur_charging;
    logic cur_pulsing;
    logic cur_door;

    assign cur_locked   = locked_reg[ptr_reg];
    assign cur_charging = charging_reg[ptr_reg];
    assign cur_pulsing  = pulsing_reg[ptr_reg];
    assign cur_door     = door_reg[ptr_reg];

    // Elapsed pulse time, one entry per slot. Only used while the slot is
    // pulsing, and unlock zeroes it, so it needs no reset.
    logic [15:0] elapsed_mem [NUM_SLOTS];
    logic [15:0] elapsed_rd_reg;
    logic [15:0] elapsed_inc;
    logic        mem_we;
    logic [15:0] mem_wdata;
    logic        pulse_end;

    assign elapsed_inc = (elapsed_rd_reg == 16'hFFFF) ? elapsed_rd_reg
                                                      : elapsed_rd_reg + 16'd1;
    assign pulse_end   = cur_pulsing && (elapsed_inc >= pulse_ticks_reg);

    assign mem_we    = (ctl.tick_step && cur_pulsing) ||
                       (ctl.cmd_apply && cmd_reg == lsc_pkg::CMD_UNLOCK);
    assign mem_wdata = ctl.tick_step ? elapsed_inc : 16'd0;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            elapsed_mem[ptr_reg] <= mem_wdata;
        end
        if (ctl.tick_rd) begin
            elapsed_rd_reg <= elapsed_mem[ptr_reg];
        end
    end

    // Door check.
    logic door_in_range;
    logic door_ok;

    assign door_in_range = {1'b0, local_index_reg} < NUM_SLOTS_W6;
    assign door_ok       = door_in_range && (first_reg != cur_door) &&
                           (confirm_reg == first_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            locked_reg   <= '0;
            charging_reg <= '0;
            pulsing_reg  <= '0;
            door_reg     <= '1;
        end else begin
            if (ctl.cmd_apply) begin
                unique case (cmd_reg)
                    lsc_pkg::CMD_UNLOCK: begin
                        locked_reg[ptr_reg]   <= 1'b0;
                        charging_reg[ptr_reg] <= 1'b0;
                        pulsing_reg[ptr_reg]  <= 1'b1;
                    end
                    lsc_pkg::CMD_CHARGE_ON: begin
                        locked_reg[ptr_reg]   <= 1'b1;
                        charging_reg[ptr_reg] <= 1'b1;
                    end
                    lsc_pkg::CMD_CHARGE_OFF: begin
                        charging_reg[ptr_reg] <= 1'b0;
                    end
                    default: ;
                endcase
            end
            if (ctl.tick_step && pulse_end) begin
                pulsing_reg[ptr_reg] <= 1'b0;
            end
            if (ctl.door_commit) begin
                door_reg[ptr_reg] <= first_reg;
            end
        end
    end

    // One result is held back so that the last one of a request can be
    // marked once the walk is over.
    logic        hold_valid_reg;
    logic [1:0]  hold_kind_reg;
    logic [5:0]  hold_id_reg;
    logic        hold_lock_reg;
    logic        hold_chg_reg;
    logic [1:0]  hold_led_reg;
    logic        hold_door_reg;

    logic out_free;
    logic push_mid;
    logic push_any;
    logic new_hold;

    assign out_free = !m_valid || m_ready;
    assign push_mid = ctl.tick_step && pulse_end && hold_valid_reg;
    assign push_any = push_mid || ctl.push_last;
    assign new_hold = ctl.build_slot || ctl.build_fwd || ctl.door_commit ||
                      (ctl.tick_step && pulse_end);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else if (new_hold) begin
            hold_valid_reg <= 1'b1;
        end else if (ctl.push_last) begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.build_fwd) begin
            hold_kind_reg <= lsc_pkg::KIND_FORWARD;
            hold_id_reg   <= id_reg;
            hold_lock_reg <= 1'b0;
            hold_chg_reg  <= 1'b0;
            hold_led_reg  <= lsc_pkg::LED_GREEN;
            hold_door_reg <= 1'b0;
        end else if (new_hold) begin
            hold_id_reg   <= lsc_pkg::ID_TABLE[ptr_reg];
            hold_chg_reg  <= cur_charging;
            hold_led_reg  <= lsc_pkg::led_of(cur_locked, cur_charging);
            if (ctl.door_commit) begin
                hold_kind_reg <= lsc_pkg::KIND_DOOR;
                hold_lock_reg <= cur_pulsing;
                hold_door_reg <= first_reg;
            end else if (ctl.build_slot) begin
                hold_kind_reg <= lsc_pkg::KIND_UPDATE;
                hold_lock_reg <= cur_pulsing;
                hold_door_reg <= 1'b0;
            end else begin
                hold_kind_reg <= lsc_pkg::KIND_PULSE_END;
                hold_lock_reg <= 1'b0;
                hold_door_reg <= 1'b0;
            end
        end
    end

    // Output register.
    logic m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (push_any) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_any) begin
            m_kind         <= hold_kind_reg;
            m_out_slot_id  <= hold_id_reg;
            m_lock_drive   <= hold_lock_reg;
            m_charge_drive <= hold_chg_reg;
            m_led_color    <= hold_led_reg;
            m_door_level   <= hold_door_reg;
            m_last         <= ctl.push_last;
        end
    end

    assign m_valid = m_valid_reg;

    always_comb begin
        status            = '0;
        status.cmd        = cmd_reg;
        status.hit        = hit;
        status.fwd_ok     = (id_reg != 6'd0) && (id_reg <= highest_remote_reg);
        status.door_ok    = door_ok;
        status.tick_stall = pulse_end && hold_valid_reg && !out_free;
        status.ptr_last   = (ptr_reg == LAST_IDX);
        status.hold_valid = hold_valid_reg;
        status.out_free   = out_free;
    end

    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        push_any |-> out_free)
        else $error("result pushed over an unaccepted result");

    a_stall_keeps_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.tick_step == 1'b0 && status.tick_stall) |=> $stable(pulsing_reg))
        else $error("pulse flags changed while a slot check was stalled");

    a_pulse_end_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.tick_step && pulse_end) |=> hold_valid_reg &&
            hold_kind_reg == lsc_pkg::KIND_PULSE_END)
        else $error("ended pulse not captured as a result");

endmodule

`default_nettype wire
